// ===== rtl/meter_packet_deframe_decode_defines.svh =====
// Assertion macros shared by the meter packet deframer RTL.
// Each macro expects signals named clk and rst in the calling module.
`ifndef METER_PACKET_DEFRAME_DECODE_DEFINES_SVH
`define METER_PACKET_DEFRAME_DECODE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MPDD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MPDD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mpdd_pkg.sv =====
// Shared types, constants and helpers for the meter packet deframer.
// No dependencies; imported by the top, scanner and field decoder modules.
package mpdd_pkg;

  // Frame layout
  localparam int FRAME_LEN   = 15;
  localparam int HDR_LEN     = 4;
  localparam int OFF_DIGIT0  = 5;
  localparam int OFF_DIGIT1  = 6;
  localparam int OFF_DIGIT2  = 7;
  localparam int OFF_DIGIT3  = 8;
  localparam int OFF_DEC     = 9;
  localparam int OFF_UNIT    = 10;
  localparam int OFF_FLAGS   = 13;

  // Byte values
  localparam logic [7:0] SYNC_BYTE = 8'hd5;
  localparam logic [7:0] HDR_BYTE1 = 8'hf0;
  localparam logic [7:0] HDR_BYTE2 = 8'h00;
  localparam logic [7:0] HDR_BYTE3 = 8'h0a;
  localparam logic [7:0] NIL_DIGIT = 8'h0f;
  localparam logic [7:0] OVR_DIG0  = 8'h0b;
  localparam logic [7:0] OVR_DIG1  = 8'h0a;
  localparam logic [7:0] OVR_DIG2  = 8'h00;
  localparam logic [7:0] OVR_DIG3  = 8'h0b;
  localparam logic [7:0] UNIT_EXTRA = 8'h0a;

  // Flag byte bit positions
  localparam int FLAG_AC  = 7;
  localparam int FLAG_DC  = 6;
  localparam int FLAG_OK  = 4;
  localparam int FLAG_MIN = 3;
  localparam int FLAG_MAX = 2;
  localparam logic [7:0] LEFTOVER_MASK = 8'h23;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_chunk;
  } in_word_t;

  typedef struct packed {
    logic        packet_valid;
    logic [13:0] reading;
    logic        overrange;
    logic [7:0]  decimal_count;
    logic [7:0]  unit_code;
    logic        unit_known;
    logic [4:0]  mode_bits;
    logic [7:0]  leftover_bits;
    logic        bad_digit;
    logic        bytes_dropped;
  } out_word_t;

  // Packet bytes captured during the scan
  typedef struct packed {
    logic [3:0][7:0] digits;
    logic [7:0]      dec;
    logic [7:0]      unit;
    logic [7:0]      flags;
  } frame_bytes_t;

  // Scanner status toward the sequencer
  typedef struct packed {
    logic hdr_ok;
    logic b0_sync;
    logic pos_found;
    logic stop;
  } scan_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Expected header byte by position
  function automatic logic [7:0] hdr_byte(input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = SYNC_BYTE;
      2'd1:    b = HDR_BYTE1;
      2'd2:    b = HDR_BYTE2;
      default: b = HDR_BYTE3;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/meter_packet_deframe_decode.sv =====
// Meter packet deframer. Bytes are kept in a ring buffer of BUF_DEPTH bytes
// held in one synchronous RAM; a byte that is not the last of its chunk is
// taken at once and the block is ready again the next cycle. At a chunk
// end the block reads the buffer back through the single RAM read port, one
// byte a cycle, until the first sync byte 0xd5 past the start is found (after
// the packet fields while the header holds), byte zero is a sync with a bad
// header, or the fill is exhausted; the scan examines 16 bytes for a plain
// packet followed by its successor's sync byte, up to the fill count when no
// sync byte follows. The leading discard is a head pointer move, so no bytes
// are copied. One result word per chunk end; the input stalls during the scan
// and until the finished result is placed in the output register.
// Depends on mpdd_pkg, mpdd_ring_mem, mpdd_frame_scan, mpdd_field_dec.
`include "meter_packet_deframe_decode_defines.svh"

module meter_packet_deframe_decode #(
  parameter int BUF_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  mpdd_pkg::in_word_t  data_word,
  output logic                result_valid,
  input  logic                result_stall,
  output mpdd_pkg::out_word_t result_word
);
  import mpdd_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);

  state_t        state;
  state_t        state_next;
  logic [AW-1:0] head;
  logic [CW-1:0] fill_count;
  logic          drop_seen;
  logic [CW-1:0] rd_off;
  logic          pr_valid;
  logic [AW-1:0] pr_off;

  logic          accept;
  logic          room;
  logic [CW-1:0] count_after;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          out_free;
  logic          finish;
  logic [7:0]    rd_data;
  logic [CW-1:0] disc;
  logic [AW-1:0] head_next;

  scan_stat_t    stat;
  logic [AW-1:0] sync_pos;
  frame_bytes_t  fields;
  out_word_t     dec_word;

  // ring index wrap for a sum below twice the depth
  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] lim;
    lim = (AW+1)'(BUF_DEPTH);
    return (s >= lim) ? AW'(s - lim) : AW'(s);
  endfunction

  // address and count arithmetic
  always_comb begin
    accept      = data_valid && !data_stall;
    room        = (fill_count != CW'(BUF_DEPTH));
    count_after = room ? fill_count + CW'(1) : fill_count;
    wr_addr     = wrap((AW+1)'(head) + (AW+1)'(fill_count));
    rd_addr     = wrap((AW+1)'(head) + (AW+1)'(rd_off));
    disc        = (stat.b0_sync && !stat.hdr_ok) ? '0 :
                  (stat.pos_found ? CW'(sync_pos) : fill_count);
    head_next   = wrap((AW+1)'(head) + (AW+1)'(disc));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && data_word.last_of_chunk) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.stop) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    out_free   = !result_valid || !result_stall;
    data_stall = (state != ST_IDLE);
    rd_en      = (state == ST_SCAN) && (rd_off < fill_count);
    finish     = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // buffer pointers, drop flag and read sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      fill_count <= '0;
      drop_seen  <= 1'b0;
      rd_off     <= '0;
      pr_valid   <= 1'b0;
    end else begin
      pr_valid <= rd_en;
      if (accept) begin
        fill_count <= count_after;
        rd_off     <= '0;
        if (!room) begin
          drop_seen <= 1'b1;
        end
      end else if (rd_en) begin
        rd_off <= rd_off + CW'(1);
      end
      if (finish) begin
        head       <= head_next;
        fill_count <= fill_count - disc;
        drop_seen  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pr_off <= rd_off[AW-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result_word <= dec_word;
    end
  end

  mpdd_ring_mem #(
    .DEPTH(BUF_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (accept && room),
    .wr_addr (wr_addr),
    .wr_data (data_word.data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr[AW-1:0]),
    .rd_data (rd_data)
  );

  mpdd_frame_scan #(
    .DEPTH(BUF_DEPTH)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (accept && data_word.last_of_chunk),
    .long_enough (count_after >= CW'(FRAME_LEN)),
    .byte_valid  (pr_valid && (state == ST_SCAN)),
    .byte_off    (pr_off),
    .byte_data   (rd_data),
    .fill_count  (fill_count),
    .stat        (stat),
    .sync_pos    (sync_pos),
    .fields      (fields)
  );

  mpdd_field_dec u_dec (
    .fields  (fields),
    .decoded (stat.hdr_ok),
    .dropped (drop_seen),
    .word    (dec_word)
  );

  // checks
  `MPDD_ASSERT_NOW(a_fill_bound, 1'b1, fill_count <= CW'(BUF_DEPTH), "fill count beyond depth")
  `MPDD_ASSERT_NOW(a_result_src, $rose(result_valid), $past(state) == ST_DONE, "result without scan")
  `MPDD_ASSERT_NOW(a_read_inside, pr_valid && (state == ST_SCAN), CW'(pr_off) < fill_count, "scan read past fill")
  `MPDD_ASSERT_NEXT(a_discard_shrinks, finish, fill_count <= $past(fill_count), "discard grew buffer")

endmodule

// ===== rtl/mpdd_ring_mem.sv =====
// Byte ring storage: one write port, one read port with registered data.
// Uses no package items.
module mpdd_ring_mem #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/mpdd_frame_scan.sv =====
// Walks buffered bytes as they return from memory: header check, field
// capture and search for the first sync byte. Depends on mpdd_pkg.
module mpdd_frame_scan #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  long_enough,
  input  logic                  byte_valid,
  input  logic [AW-1:0]         byte_off,
  input  logic [7:0]            byte_data,
  input  logic [CW-1:0]         fill_count,
  output mpdd_pkg::scan_stat_t  stat,
  output logic [AW-1:0]         sync_pos,
  output mpdd_pkg::frame_bytes_t fields
);
  import mpdd_pkg::*;

  logic hdr_ok;
  logic b0_sync;
  logic pos_found;
  logic is_sync;
  logic at_zero;
  logic hdr_now;
  logic b0_now;
  logic found_now;
  logic need_more;
  logic at_end;

  // view including the byte being processed
  always_comb begin
    is_sync   = (byte_data == SYNC_BYTE);
    at_zero   = (byte_off == '0);
    hdr_now   = hdr_ok && ((byte_off >= AW'(HDR_LEN)) ||
                           (byte_data == hdr_byte(byte_off[1:0])));
    b0_now    = at_zero ? is_sync : b0_sync;
    found_now = pos_found || (!at_zero && is_sync);
    // a live header keeps the scan going until the flag byte is in
    need_more = hdr_now && (byte_off < AW'(OFF_FLAGS));
    at_end    = (CW'(byte_off) == fill_count - CW'(1));
  end

  assign stat.hdr_ok    = hdr_ok;
  assign stat.b0_sync   = b0_sync;
  assign stat.pos_found = pos_found;
  assign stat.stop      = byte_valid &&
                          (at_end || (!need_more && (found_now || (b0_now && !hdr_now))));

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_ok    <= 1'b0;
      b0_sync   <= 1'b0;
      pos_found <= 1'b0;
    end else if (start) begin
      hdr_ok    <= long_enough;
      b0_sync   <= 1'b0;
      pos_found <= 1'b0;
    end else if (byte_valid) begin
      hdr_ok    <= hdr_now;
      b0_sync   <= b0_now;
      pos_found <= found_now;
    end
  end

  // first sync position past offset zero
  always_ff @(posedge clk) begin
    if (byte_valid && !pos_found && !at_zero && is_sync) begin
      sync_pos <= byte_off;
    end
  end

  // field capture by offset
  always_ff @(posedge clk) begin
    if (byte_valid) begin
      case (byte_off)
        AW'(OFF_DIGIT0): fields.digits[0] <= byte_data;
        AW'(OFF_DIGIT1): fields.digits[1] <= byte_data;
        AW'(OFF_DIGIT2): fields.digits[2] <= byte_data;
        AW'(OFF_DIGIT3): fields.digits[3] <= byte_data;
        AW'(OFF_DEC):    fields.dec       <= byte_data;
        AW'(OFF_UNIT):   fields.unit      <= byte_data;
        AW'(OFF_FLAGS):  fields.flags     <= byte_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/mpdd_field_dec.sv =====
// Turns captured packet bytes into the result word.
// Depends on mpdd_pkg.
module mpdd_field_dec (
  input  mpdd_pkg::frame_bytes_t fields,
  input  logic                   decoded,
  input  logic                   dropped,
  output mpdd_pkg::out_word_t    word
);
  import mpdd_pkg::*;

  logic [3:0][3:0] dval;
  logic [3:0]      dbad;
  logic            over;
  logic [13:0]     value;

  // per-digit value and bad flag
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      dval[k] = '0;
      dbad[k] = 1'b0;
      if (fields.digits[k] == NIL_DIGIT) begin
        dval[k] = '0;
      end else if (fields.digits[k] > 8'd9) begin
        dbad[k] = 1'b1;
      end else begin
        dval[k] = fields.digits[k][3:0];
      end
    end
  end

  // overrange pattern and digit sum
  always_comb begin
    over  = (fields.digits[0] == OVR_DIG0) && (fields.digits[1] == OVR_DIG1) &&
            (fields.digits[2] == OVR_DIG2) && (fields.digits[3] == OVR_DIG3);
    value = 14'(dval[0]) + 14'(dval[1]) * 14'd10 +
            14'(dval[2]) * 14'd100 + 14'(dval[3]) * 14'd1000;
  end

  // result assembly; no packet leaves only the drop flag
  always_comb begin
    word = '0;
    if (decoded) begin
      word.packet_valid  = 1'b1;
      word.reading       = over ? 14'd0 : value;
      word.overrange     = over;
      word.decimal_count = fields.dec;
      word.unit_code     = fields.unit;
      word.unit_known    = (fields.unit inside {[8'h01:8'h07]}) ||
                           (fields.unit == UNIT_EXTRA);
      word.mode_bits     = {fields.flags[FLAG_AC], fields.flags[FLAG_DC],
                            fields.flags[FLAG_OK], fields.flags[FLAG_MIN],
                            fields.flags[FLAG_MAX]};
      word.leftover_bits = fields.flags & LEFTOVER_MASK;
      word.bad_digit     = !over && (|dbad);
    end
    word.bytes_dropped = dropped;
  end

endmodule
